// ----- rtl/core/windowed_moving_average_unit_assert.svh -----
// assertion macros for the windowed moving average unit
// expects signals named clock and reset in the module that includes it
`ifndef WINDOWED_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WMA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define WMA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/wma_pkg.sv -----
// shared constants and control types of the windowed moving average unit
// no dependencies
`default_nettype none

package wma_pkg;

   localparam int MAX_WINDOW_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int WIN_BITS = 7;
   localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd8;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;    // capture request sample, read oldest ring entry
      logic update;    // update sum, count, pointer and ring
      logic div_load;  // load divider with magnitude of sum
      logic div_step;  // one restoring division step
      logic out_load;  // load result register
   } wma_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic out_free;  // result register can take a new value this cycle
   } wma_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/wma_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module wma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/wma_ctrl.sv -----
// sequencing state machine of the windowed moving average unit
// depends on wma_pkg and windowed_moving_average_unit_assert.svh
`default_nettype none

`include "windowed_moving_average_unit_assert.svh"

module wma_ctrl #(
   parameter int MAX_WINDOW  = wma_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire wma_pkg::wma_status_type status,
   output wma_pkg::wma_cmd_type         cmd
);

   import wma_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = STEP_W'(SUM_W - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `WMA_ASSERT_NEXT(a_accept_to_update, cmd.accept, state_ff == ST_UPDATE,
      "accepted request did not move to update")
   `WMA_ASSERT_NEXT(a_div_ends, (state_ff == ST_DIV) && (step_ff == '0),
      state_ff == ST_DONE, "division did not end after its last step")
   `WMA_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd),
      "more than one datapath command at once")

endmodule

`default_nettype wire

// ----- rtl/core/wma_dpath.sv -----
// datapath: window register, running sum, fill count, ring pointer,
// serial divider and result register; depends on wma_pkg, wma_ram, assert header
`default_nettype none

`include "windowed_moving_average_unit_assert.svh"

module wma_dpath #(
   parameter int MAX_WINDOW  = wma_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]            rsp_average,
   input  wire logic                                csr_wr_en,
   input  wire logic [wma_pkg::WIN_BITS-1:0]        csr_wr_data,
   input  wire wma_pkg::wma_cmd_type                cmd,
   output wma_pkg::wma_status_type                  status
);

   import wma_pkg::*;

   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_BITS + PTR_W;
   localparam int EW    = (CNT_W > WIN_BITS) ? CNT_W : WIN_BITS;

   function automatic logic [CNT_W-1:0] clamp_window(input logic [WIN_BITS-1:0] v);
      logic [EW-1:0] ext;
      ext = EW'(v);
      priority if (ext == '0) begin
         clamp_window = CNT_W'(1);
      end else if (ext > EW'(MAX_WINDOW)) begin
         clamp_window = CNT_W'(MAX_WINDOW);
      end else begin
         clamp_window = CNT_W'(ext);
      end
   endfunction

   logic [CNT_W-1:0]              win_ff, win_in;
   logic [PTR_W-1:0]              ptr_ff, ptr_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          neg_ff;
   logic [SUM_W-1:0]              dq_ff;
   logic [CNT_W-1:0]              rem_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_average_ff;

   logic [SAMPLE_BITS-1:0]        ring_rdata;
   logic                          full;
   logic signed [SUM_W-1:0]       oldest;
   logic                          wrap;
   logic [CNT_W:0]                shifted;
   logic                          ge;
   logic [SUM_W-1:0]              q_adj;
   logic [SUM_W-1:0]              avg_full;

   wma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (ptr_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.accept),
      .rd_addr (ptr_ff),
      .rd_data (ring_rdata)
   );

   assign full   = (cnt_ff == win_ff);
   assign oldest = full ? SUM_W'($signed(ring_rdata)) : '0;
   assign wrap   = ((CNT_W'(ptr_ff) + 1'b1) == win_ff);

   always_comb begin
      win_in = win_ff;
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      priority if (csr_wr_en) begin
         win_in = clamp_window(csr_wr_data);
         ptr_in = '0;
         cnt_in = '0;
         sum_in = '0;
      end else if (cmd.update) begin
         sum_in = sum_ff + SUM_W'(sample_ff) - oldest;
         cnt_in = full ? cnt_ff : cnt_ff + 1'b1;
         ptr_in = wrap ? '0 : ptr_ff + 1'b1;
      end
   end

   // restoring division, one quotient bit per step
   assign shifted = {rem_ff, dq_ff[SUM_W-1]};
   assign ge      = (shifted >= {1'b0, cnt_ff});

   // floor rounding: a negative sum with a remainder goes one further down
   assign q_adj    = dq_ff + SUM_W'(neg_ff && (rem_ff != '0));
   assign avg_full = neg_ff ? (~q_adj + 1'b1) : q_adj;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= clamp_window(WIN_RESET);
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
      if (cmd.div_load) begin
         neg_ff <= sum_ff[SUM_W-1];
         dq_ff  <= sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff  <= {dq_ff[SUM_W-2:0], ge};
         rem_ff <= ge ? CNT_W'(shifted - {1'b0, cnt_ff}) : shifted[CNT_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_average_ff <= avg_full[SAMPLE_BITS-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   `WMA_ASSERT_NOW(a_fill_in_window, 1'b1,
      (cnt_ff <= win_ff) && (CNT_W'(ptr_ff) < win_ff),
      "fill count or ring pointer outside the window")
   `WMA_ASSERT_NOW(a_div_nonzero, cmd.div_load || cmd.div_step, cnt_ff != '0,
      "division by a zero fill count")
   `WMA_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid_ff || !rsp_stall,
      "result register overwritten while stalled")

endmodule

`default_nettype wire

// ----- rtl/core/windowed_moving_average_unit.sv -----
// one request at a time: req_stall is high after accept until the result is loaded
//   into the output register; the pace is set by the one-bit-per-cycle restoring
//   divider, SUM_W = SAMPLE_BITS + log2(MAX_WINDOW)
// reset: synchronous, active high; window returns to 8, sum, count and
//   pointer clear, no result pending; the ring needs no clearing pass
`default_nettype none

module windowed_moving_average_unit #(
   parameter int MAX_WINDOW  = wma_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel: one sample per request
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   // result channel: floor of window sum over fill count
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_average,
   // window length register, any write restarts the filter
   input  wire logic                          csr_wr_en,
   input  wire logic [wma_pkg::WIN_BITS-1:0]  csr_wr_data
);

   import wma_pkg::*;

   wma_cmd_type    cmd;
   wma_status_type status;

   // controller: idle -> update -> divider load -> divide steps -> result
   // a new request is taken as soon as the previous result sits in the
   // output register, even if the consumer is still stalling it
   wma_ctrl #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: ring of past samples in ram, running sum and fill count,
   // serial divider with floor correction, output register
   wma_dpath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

// ----- tb/moving_average_checker.sv -----
`timescale 1ns / 100ps
// checker for the windowed moving average unit: tracks window register and filter state,
// predicts every average and compares it with the result channel
// depends on wma_pkg for the window register width, its reset value and the default sizes
module moving_average_checker #(
   parameter int MAX_WINDOW  = wma_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = wma_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_sample,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]        rsp_average,
   input  wire logic                                 csr_wr_en,
   input  wire logic [wma_pkg::WIN_BITS-1:0]         csr_wr_data,
   output int                                        mismatch_count,
   output int                                        pending_count
);

   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int SUM_W = SAMPLE_BITS + PTR_W;
   localparam int REPORT_LIMIT = 10;
   // far more than the block can ever hold in flight
   localparam int EXP_DEPTH = 16;
   localparam int EXP_PTR_W = $clog2(EXP_DEPTH);

   logic [wma_pkg::WIN_BITS-1:0]  window_reg;
   logic signed [SAMPLE_BITS-1:0] sample_ring [MAX_WINDOW];
   logic [PTR_W-1:0]              ring_ptr;
   logic [PTR_W:0]                fill_count;
   logic signed [SUM_W-1:0]       window_sum;
   logic signed [SAMPLE_BITS-1:0] expected_averages [EXP_DEPTH];
   logic [EXP_PTR_W-1:0]          exp_wr_ptr;
   logic [EXP_PTR_W-1:0]          exp_rd_ptr;
   int                            exp_count;

   // zero behaves as one, anything past the ring size as the ring size
   function automatic int effective_window(input logic [wma_pkg::WIN_BITS-1:0] length);
      if (length == 0) return 1;
      if (length > MAX_WINDOW) return MAX_WINDOW;
      return int'(length);
   endfunction

   task automatic restart_filter();
      ring_ptr   = '0;
      fill_count = '0;
      window_sum = '0;
   endtask

   task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      int span;
      int slot;
      int num;
      int den;
      int quot;
      span = effective_window(window_reg);
      slot = int'(ring_ptr) % span;
      if (int'(fill_count) < span) fill_count = fill_count + 1'b1;
      else window_sum = window_sum - sample_ring[slot];
      window_sum = window_sum + sample;
      sample_ring[slot] = sample;
      ring_ptr = PTR_W'((slot + 1) % span);
      // floor division, the language truncates toward zero
      num  = window_sum;
      den  = int'(fill_count);
      quot = num / den;
      if ((num % den) != 0 && num < 0) quot = quot - 1;
      if (exp_count == EXP_DEPTH) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: too many requests waiting for an average", $realtime);
      end else begin
         expected_averages[exp_wr_ptr] = SAMPLE_BITS'(quot);
         exp_wr_ptr = exp_wr_ptr + 1'b1;
         exp_count++;
      end
   endtask

   always @(posedge clock) begin
      logic signed [SAMPLE_BITS-1:0] expected;
      if (reset) begin
         window_reg = wma_pkg::WIN_RESET;
         restart_filter();
         exp_wr_ptr = '0;
         exp_rd_ptr = '0;
         exp_count  = 0;
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            window_reg = csr_wr_data;
            restart_filter();
         end
         // results before requests so a same-edge request never matches itself
         if (rsp_valid && !rsp_stall) begin
            if (exp_count == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: average %0d with no request waiting", $realtime, rsp_average);
            end else begin
               expected   = expected_averages[exp_rd_ptr];
               exp_rd_ptr = exp_rd_ptr + 1'b1;
               exp_count--;
               if (rsp_average !== expected) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: average mismatch, expected %0d got %0d",
                              $realtime, expected, rsp_average);
               end
            end
         end
         if (req_valid && !req_stall) take_sample(req_sample);
      end
      pending_count = exp_count;
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// top of the windowed moving average unit testbench: clock, reset, stimulus and verdict
// depends on wma_pkg, windowed_moving_average_unit and moving_average_checker
module testbench;

   import wma_pkg::*;

   localparam int SW = SAMPLE_BITS_DEF;
   localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam int RANDOM_ITEMS   = 1600;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;

   // how the samples of one phase are drawn
   typedef enum int {SPREAD_FULL, SPREAD_SMALL, SPREAD_RAIL, SPREAD_MIXED} sample_spread_type;

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   logic signed [SW-1:0]    req_sample  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   logic signed [SW-1:0]    rsp_average;
   logic                    csr_wr_en   = 1'b0;
   logic [WIN_BITS-1:0]     csr_wr_data = '0;

   int  mismatch_count;
   int  pending_count;
   int  idle_cycles = 0;
   int  stall_hold  = 0;
   bit  no_gaps     = 1'b0;

   windowed_moving_average_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_average (rsp_average),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   moving_average_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_average    (rsp_average),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // result side back-pressure: each choice is held for a while, so there are
   // short blips, long stalls and long stretches with no stall at all
   always @(negedge clock) begin
      int pick;
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 40);
         end else if (pick < 85) begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 3);
         end else if (pick < 95) begin
            rsp_stall  <= 1'b0;
            stall_hold <= 200;
         end else begin
            rsp_stall  <= 1'b1;
            stall_hold <= $urandom_range(10, 60);
         end
      end
   end

   // watchdog: too long without any request or result moving ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   // request side gap in cycles, mostly none, sometimes a few, rarely many
   function automatic int pick_gap();
      int pick;
      if (no_gaps) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic logic signed [SW-1:0] pick_sample(input sample_spread_type spread,
                                                        input logic signed [SW-1:0] rail);
      case (spread)
         SPREAD_FULL:  return SW'($urandom);
         // small values around zero make inexact negative quotients common
         SPREAD_SMALL: return SW'($urandom_range(0, 16) - 8);
         // one rail held for the whole phase drives the sum to its extremes
         SPREAD_RAIL:  return rail;
         default: begin
            if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            return SW'($urandom);
         end
      endcase
   endfunction

   // one request: optional gap with valid low and junk payload, then hold the
   // sample with valid high until it is taken
   task automatic send_sample(input logic signed [SW-1:0] sample);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid  <= 1'b0;
         req_sample <= SW'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // drop valid and wait for every outstanding average to come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // only called once settled, any write restarts the filter
   task automatic write_window(input logic [WIN_BITS-1:0] length);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= WIN_BITS'($urandom);
   endtask

   function automatic logic [WIN_BITS-1:0] pick_window();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         case ($urandom_range(0, 6))
            0:       return WIN_BITS'(0);
            1:       return WIN_BITS'(1);
            2:       return WIN_BITS'(2);
            3:       return WIN_BITS'(63);
            4:       return WIN_BITS'(64);
            5:       return WIN_BITS'(65);
            default: return WIN_BITS'(127);
         endcase
      end
      if (pick < 70) return WIN_BITS'($urandom_range(1, 16));
      return WIN_BITS'($urandom_range(0, 127));
   endfunction

   initial begin
      logic signed [SW-1:0] warm_up [10];
      logic signed [SW-1:0] rail;
      sample_spread_type    spread;
      int                   phase_items;
      int                   sent;

      warm_up = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                  -16'sd1, 16'sd1, 16'sd0, 16'sd5};
      sent = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window of eight: rails, a negative inexact mean, then wrap-around
      foreach (warm_up[i]) send_sample(warm_up[i]);

      // window zero behaves as one, each average is the sample itself
      settle();
      write_window(WIN_BITS'(0));
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(-16'sd3);

      // oversized window clamps to the ring size
      settle();
      write_window(WIN_BITS'(127));
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(16'sd1);

      // rewriting the same length still restarts the filter
      settle();
      write_window(WIN_BITS'(64));
      send_sample(16'sd7);
      settle();
      write_window(WIN_BITS'(64));
      send_sample(-16'sd7);

      settle();
      write_window(WIN_BITS'(1));
      send_sample(16'sd100);
      send_sample(-16'sd100);

      // random phases: new window, new sample spread, sometimes no request gaps;
      // a phase sends 1 to 40 requests, or 60 to 200 in one phase out of four
      while (sent < RANDOM_ITEMS) begin
         settle();
         write_window(pick_window());
         spread      = sample_spread_type'($urandom_range(0, 3));
         rail        = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         no_gaps     = ($urandom_range(0, 4) == 0);
         phase_items = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 40);
         repeat (phase_items) begin
            send_sample(pick_sample(spread, rail));
            sent++;
         end
      end

      // drain, then allow for a stray late result
      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
